/* design/bskd_pkg.sv */
// ----------------------------------------------------------------------------
// bskd_pkg
// shared types and constants for the bounded stack with keyed delete
// ----------------------------------------------------------------------------
package bskd_pkg;

  localparam int KEY_W        = 16;
  localparam int FILL_W       = 7;
  localparam int CAPACITY_DEF = 8;

  localparam logic OP_PUSH   = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_PUSHED   = 2'd0,
    ST_FULL     = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic             opcode;
    logic [KEY_W-1:0] key;
  } in_word_t;

  typedef struct packed {
    status_t           status;
    logic [FILL_W-1:0] fill_count;
    logic              has_room;
  } out_word_t;

  typedef struct packed {
    logic capture;
    logic apply;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

endpackage

/* design/bskd_ctrl.sv */
// ----------------------------------------------------------------------------
// bskd_ctrl
// request sequencer: capture and search, then apply and post result
// ----------------------------------------------------------------------------
module bskd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output bskd_pkg::cmd_t cmd,
  input  bskd_pkg::stat_t stat
);
  import bskd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_APPLY = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    in_stall    = 1'b1;
    cmd.capture = 1'b0;
    cmd.apply   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_APPLY;
        end
      end
      S_APPLY: begin
        if (!stat.out_busy) begin
          cmd.apply = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/bskd_dp.sv */
// ----------------------------------------------------------------------------
// bskd_dp
// entry cells, parallel key compare, shifting delete and result register
// ----------------------------------------------------------------------------
module bskd_dp #(
  parameter int Capacity = bskd_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bskd_pkg::in_word_t  in_data,
  input  bskd_pkg::cmd_t      cmd,
  output bskd_pkg::stat_t     stat,
  output logic                out_valid,
  input  logic                out_stall,
  output bskd_pkg::out_word_t out_data
);
  import bskd_pkg::*;

  localparam logic [FILL_W-1:0] CAP_FILL = FILL_W'(Capacity);

  logic [KEY_W-1:0]  entries_r [Capacity];
  logic [FILL_W-1:0] occ_r, occ_nxt;
  logic              op_r;
  logic [KEY_W-1:0]  key_r;
  logic              found_r;
  logic [FILL_W-1:0] pos_r;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_data_r, out_data_nxt;

  logic              hit;
  logic [FILL_W-1:0] hit_pos;
  logic              full;
  logic              push_en;
  logic              del_en;

  // topmost matching entry below the fill level
  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int i = 0; i < Capacity; i++) begin
      if ((FILL_W'(i) < occ_r) && (entries_r[i] == in_data.key)) begin
        hit     = 1'b1;
        hit_pos = FILL_W'(i);
      end
    end
  end

  assign full    = (occ_r >= CAP_FILL);
  assign push_en = cmd.apply && (op_r == OP_PUSH) && !full;
  assign del_en  = cmd.apply && (op_r == OP_REMOVE) && found_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_data.opcode;
      key_r   <= in_data.key;
      found_r <= hit;
      pos_r   <= hit_pos;
    end
  end

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    if (g < Capacity - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (push_en && (occ_r == FILL_W'(g))) begin
          entries_r[g] <= key_r;
        end else if (del_en && (pos_r <= FILL_W'(g))) begin
          entries_r[g] <= entries_r[g+1];
        end
      end
    end else begin : g_top
      always_ff @(posedge clk) begin
        if (push_en && (occ_r == FILL_W'(g))) begin
          entries_r[g] <= key_r;
        end
      end
    end
  end

  always_comb begin
    occ_nxt      = occ_r;
    out_data_nxt = out_data_r;
    if (cmd.apply) begin
      if (op_r == OP_PUSH) begin
        if (full) begin
          out_data_nxt.status = ST_FULL;
        end else begin
          occ_nxt             = occ_r + FILL_W'(1);
          out_data_nxt.status = ST_PUSHED;
        end
      end else begin
        if (found_r) begin
          occ_nxt             = occ_r - FILL_W'(1);
          out_data_nxt.status = ST_REMOVED;
        end else begin
          out_data_nxt.status = ST_NOTFOUND;
        end
      end
      out_data_nxt.fill_count = occ_nxt;
      out_data_nxt.has_room   = (occ_nxt < CAP_FILL);
    end
  end

  assign out_valid_nxt = cmd.apply ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign stat.out_busy = out_valid_r && out_stall;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

endmodule

/* design/bounded_stack_with_keyed_delete.sv */
// ----------------------------------------------------------------------------
// bounded_stack_with_keyed_delete
// bounded ordered key stack with push and remove-first-match-from-top
// ----------------------------------------------------------------------------
//  channel   ports                          word
//  in        in_valid in_stall in_data      opcode, key
//  out       out_valid out_stall out_data   status, fill_count, has_room
//
//  each request is accepted with parallel key compare, then applied
//  (push or shifting delete) while the result register loads
//  a new word is accepted while the previous result still waits on out_stall
//  the apply cycle holds while the result register is occupied and stalled
//  reset empties the stack, entry contents are not cleared
// ----------------------------------------------------------------------------
module bounded_stack_with_keyed_delete #(
  parameter int Capacity = bskd_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bskd_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bskd_pkg::out_word_t out_data
);
  import bskd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bskd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  bskd_dp #(
    .Capacity (Capacity)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
